### hw/rtl/cacd_pkg.sv
// ============================================================================
// Constrained array count package
// Shared types, constants and the modular adder of the constrained array
// count block.
// ============================================================================
`default_nettype none

package cacd_pkg;

    localparam int unsigned MAX_VALUE_DEF = 128;
    localparam logic [7:0]  MAX_VALUE_RST = 8'd128;
    localparam logic [31:0] MODULUS       = 32'd1000000007;
    localparam logic [31:0] MODULUS_X2    = 32'd2000000014;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [29:0] count;
        logic        bad_value;
    } out_beat_t;

    // Sum of three residues, reduced back below the modulus.
    function automatic logic [29:0] mod_add3(input logic [29:0] a,
                                             input logic [29:0] b,
                                             input logic [29:0] c);
        logic [31:0] s;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [29:0] r;
        s  = 32'(a) + 32'(b) + 32'(c);
        s1 = s - MODULUS;
        s2 = s - MODULUS_X2;
        if (s >= MODULUS_X2) begin
            r = s2[29:0];
        end else if (s >= MODULUS) begin
            r = s1[29:0];
        end else begin
            r = s[29:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/constrained_array_count_dp_top.sv
// ============================================================================
// Constrained array count, top level
// Counts arrays with entries in 1..max_value whose neighbors differ by at
// most one, with some entries fixed, modulo 1e9+7.
// ============================================================================
//
//  Channel   Ports                         Beat
//  input     s_valid / s_ready / s_data    one array entry and its last flag
//  result    m_valid / m_ready / m_data    count and error flag, last entry only
//  config    cfg_wr_en / cfg_wr_data       max_value, written at once
//
//  An entry that starts an array writes every slot of the count row in turn;
//  any other entry primes the read of the row and then sweeps every slot. The
//  last entry also sums the row up to the effective maximum. The single read port
//  of the count row memory and the one shared modular adder set this schedule.
//  An entry that is out of range, or that follows one in the same array, skips
//  the row and returns to idle, or goes straight to the result if it is the last entry.
//  Reset is synchronous and active low; the count row needs no clearing.
//  A result waiting on m_ready stalls the block only when the next result is due.
//
`default_nettype none

module constrained_array_count_dp_top #(
    parameter int unsigned MAX_VALUE = cacd_pkg::MAX_VALUE_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cacd_pkg::in_beat_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cacd_pkg::out_beat_t     m_data
);

    localparam int unsigned IW = $clog2(MAX_VALUE);
    localparam int unsigned CW = $clog2(MAX_VALUE + 1);
    localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_VALUE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PRIME0,
        ST_PRIME1,
        ST_SWEEP,
        ST_SUMP,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       idx_reg;
    logic [7:0]          val_reg;
    logic                last_reg;
    logic [CW-1:0]       lim_reg;
    logic [29:0]         lo_reg;
    logic [29:0]         mid_reg;
    logic [29:0]         acc_reg;
    logic                expect_first_reg;
    logic                error_seen_reg;
    logic [7:0]          max_value_reg;
    logic                out_valid_reg;
    cacd_pkg::out_beat_t out_data_reg;

    logic [29:0]         row_mem [MAX_VALUE];
    logic [29:0]         rd_data_reg;

    logic [CW-1:0]       lim_now;
    logic                in_bad;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    logic [29:0]         mem_wd;
    logic [IW-1:0]       mem_ra;
    logic [29:0]         unit_a;
    logic [29:0]         unit_b;
    logic [29:0]         unit_c;
    logic [29:0]         unit_y;
    logic                slot_in_range;
    logic                slot_allowed;
    logic                upper_ok;
    logic [31:0]         idx_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        if (max_value_reg == 8'd0) begin
            lim_now = CW'(1);
        end else if (32'(max_value_reg) > 32'(MAX_VALUE)) begin
            lim_now = CW'(MAX_VALUE);
        end else begin
            lim_now = CW'(max_value_reg);
        end
    end

    assign in_bad  = (32'(s_data.value) > 32'(lim_now));
    assign idx_ext = 32'(idx_reg);

    assign slot_in_range = (idx_reg < lim_reg);
    assign slot_allowed  = slot_in_range &&
                           ((val_reg == 8'd0) || (idx_ext + 32'd1 == 32'(val_reg)));
    assign upper_ok      = (idx_ext + 32'd2 <= 32'(lim_reg));

    assign unit_y = cacd_pkg::mod_add3(unit_a, unit_b, unit_c);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx_reg[IW-1:0];
        mem_wd = '0;
        mem_ra = '0;
        unit_a = mid_reg;
        unit_b = lo_reg;
        unit_c = '0;
        unique case (state_reg)
            ST_INIT: begin
                mem_we = 1'b1;
                if (slot_allowed) begin
                    mem_wd = 30'd1;
                end
            end
            ST_PRIME1: begin
                mem_ra = IW'(1);
            end
            ST_SWEEP: begin
                mem_ra = IW'(idx_ext + 32'd2);
                unit_c = upper_ok ? rd_data_reg : '0;
                mem_we = 1'b1;
                mem_wd = slot_allowed ? unit_y : '0;
            end
            ST_SUM: begin
                mem_ra = IW'(idx_ext + 32'd1);
                unit_a = acc_reg;
                unit_b = rd_data_reg;
            end
            ST_IDLE, ST_PRIME0, ST_SUMP, ST_DONE: begin
                mem_ra = '0;
            end
            default: begin
                mem_ra = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= row_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            expect_first_reg <= 1'b1;
            error_seen_reg   <= 1'b0;
            max_value_reg    <= cacd_pkg::MAX_VALUE_RST;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_value_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        val_reg  <= s_data.value;
                        last_reg <= s_data.is_last;
                        lim_reg  <= lim_now;
                        idx_reg  <= '0;
                        lo_reg   <= '0;
                        acc_reg  <= '0;
                        priority if (in_bad) begin
                            error_seen_reg   <= 1'b1;
                            expect_first_reg <= 1'b0;
                            state_reg        <= s_data.is_last ? ST_DONE : ST_IDLE;
                        end else if (error_seen_reg) begin
                            state_reg <= s_data.is_last ? ST_DONE : ST_IDLE;
                        end else if (expect_first_reg) begin
                            expect_first_reg <= 1'b0;
                            state_reg        <= ST_INIT;
                        end else begin
                            state_reg <= ST_PRIME0;
                        end
                    end
                end
                ST_INIT: begin
                    if (idx_reg == LAST_SLOT) begin
                        idx_reg   <= '0;
                        state_reg <= last_reg ? ST_SUMP : ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_PRIME0: begin
                    state_reg <= ST_PRIME1;
                end
                ST_PRIME1: begin
                    mid_reg   <= rd_data_reg;
                    state_reg <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    lo_reg  <= mid_reg;
                    mid_reg <= rd_data_reg;
                    if (idx_reg == LAST_SLOT) begin
                        idx_reg   <= '0;
                        state_reg <= last_reg ? ST_SUMP : ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_SUMP: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    acc_reg <= unit_y;
                    if (idx_reg + CW'(1) == lim_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_data_reg.count     <= error_seen_reg ? '0 : acc_reg;
                        out_data_reg.bad_value <= error_seen_reg;
                        out_valid_reg          <= 1'b1;
                        expect_first_reg       <= 1'b1;
                        error_seen_reg         <= 1'b0;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cacd_checker.sv
// ============================================================================
// Constrained array count checker
// Port-level assertions on the constrained array count block, bound to the
// top level.
// ============================================================================
`default_nettype none

module cacd_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cacd_pkg::out_beat_t m_data
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.count) < cacd_pkg::MODULUS))
        else $error("count not reduced below the modulus");

    // An array with an entry out of range has no valid arrangement.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_value |-> (m_data.count == 30'd0))
        else $error("nonzero count with error flag");

    // After a reset edge the block is idle and holds no result.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind constrained_array_count_dp_top cacd_checker u_cacd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### test/cacd_count_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// Constrained array count monitor
// Watches the entry, result and max_value ports of the constrained array
// count block. It keeps its own row of counts per value and works out the
// count and error flag that each array's last entry must produce. It then
// compares every result beat against the oldest outstanding count.
// ============================================================================

module cacd_count_monitor #(
    parameter int unsigned MAX_VALUE = cacd_pkg::MAX_VALUE_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire cacd_pkg::in_beat_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire cacd_pkg::out_beat_t m_data,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int ROW_LEN = int'(MAX_VALUE);

    logic [29:0]         row [ROW_LEN];
    logic [7:0]          max_reg = cacd_pkg::MAX_VALUE_RST;
    logic                array_open = 1'b0;
    logic                bad_seen = 1'b0;
    cacd_pkg::out_beat_t expected_counts [$];
    int                  fail_total = 0;

    function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        if (s >= cacd_pkg::MODULUS) begin
            s = s - cacd_pkg::MODULUS;
        end
        return s[29:0];
    endfunction

    function automatic int value_limit();
        int lim;
        lim = int'(max_reg);
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > ROW_LEN) begin
            lim = ROW_LEN;
        end
        return lim;
    endfunction

    task automatic advance_count_row(input cacd_pkg::in_beat_t beat);
        int                  lim;
        int                  fixed;
        logic [29:0]         prev [ROW_LEN];
        logic [29:0]         acc;
        cacd_pkg::out_beat_t res;
        lim = value_limit();
        fixed = int'(beat.value);
        if (fixed > lim) begin
            bad_seen = 1'b1;
            foreach (row[k]) row[k] = '0;
            array_open = 1'b1;
        end else if (!array_open) begin
            for (int k = 0; k < ROW_LEN; k++) begin
                if (k + 1 > lim) begin
                    row[k] = '0;
                end else if (fixed == 0) begin
                    row[k] = 30'd1;
                end else begin
                    row[k] = (k + 1 == fixed) ? 30'd1 : 30'd0;
                end
            end
            array_open = 1'b1;
        end else begin
            prev = row;
            for (int k = 0; k < ROW_LEN; k++) begin
                if (k + 1 > lim || (fixed != 0 && k + 1 != fixed)) begin
                    row[k] = '0;
                end else begin
                    acc = prev[k];
                    if (k >= 1) begin
                        acc = add_mod(acc, prev[k-1]);
                    end
                    if (k + 2 <= lim && k + 1 < ROW_LEN) begin
                        acc = add_mod(acc, prev[k+1]);
                    end
                    row[k] = acc;
                end
            end
        end
        if (beat.is_last) begin
            acc = '0;
            for (int k = 0; k < lim; k++) begin
                acc = add_mod(acc, row[k]);
            end
            res.count = acc;
            res.bad_value = bad_seen;
            expected_counts.insert(expected_counts.size(), res);
            array_open = 1'b0;
            bad_seen = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        cacd_pkg::out_beat_t want;
        if (!aresetn) begin
            max_reg = cacd_pkg::MAX_VALUE_RST;
            array_open = 1'b0;
            bad_seen = 1'b0;
            expected_counts.delete();
        end else begin
            if (cfg_wr_en) begin
                max_reg = cfg_wr_data;
            end
            if (s_valid && s_ready === 1'b1) begin
                advance_count_row(s_data);
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, count %0d bad_value %0b",
                             $time, m_data.count, m_data.bad_value);
                    fail_total++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_data.count !== want.count) begin
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, want.count, m_data.count);
                        fail_total++;
                    end
                    if (m_data.bad_value !== want.bad_value) begin
                        $display("%0t: bad_value mismatch, expected %0b, actual %0b",
                                 $time, want.bad_value, m_data.bad_value);
                        fail_total++;
                    end
                end
            end
        end
        mismatches <= fail_total;
        outstanding <= expected_counts.size();
    end

endmodule

### test/tb_constrained_array_count_dp_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Constrained array count testbench
// Streams arrays of free and fixed entries into the block under random
// valid and ready gaps, moves max_value between arrays and now and then
// inside one, and leaves the checking of result beats to the count monitor.
// ============================================================================

module tb_constrained_array_count_dp_top;

    localparam int unsigned MAX_VALUE      = cacd_pkg::MAX_VALUE_DEF;
    localparam int          RANDOM_ENTRIES = 1850;
    localparam int          IDLE_WAIT      = 2 * (MAX_VALUE + 3) + 16;
    localparam int          LIMIT_NS       = 50_000_000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [7:0]          cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    cacd_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cacd_pkg::out_beat_t m_data;
    logic                quiet_mode = 1'b0;
    int                  ready_hold = 0;
    int                  mismatches;
    int                  outstanding;
    int                  entries_sent;
    logic [7:0]          cur_max;

    constrained_array_count_dp_top #(
        .MAX_VALUE(MAX_VALUE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    cacd_count_monitor #(
        .MAX_VALUE(MAX_VALUE)
    ) count_monitor (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (quiet_mode) begin
            m_ready <= 1'b1;
        end else if (roll < 55) begin
            m_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 3);
        end else if (roll < 85) begin
            m_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b0;
            ready_hold <= $urandom_range(10, 200);
        end
    end

    function automatic int eff_max(input logic [7:0] raw);
        int lim;
        lim = int'(raw);
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > int'(MAX_VALUE)) begin
            lim = int'(MAX_VALUE);
        end
        return lim;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_mode || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 150);
    endfunction

    function automatic logic [7:0] pick_max();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            return 8'd128;
        end else if (roll < 25) begin
            return 8'd1;
        end else if (roll < 30) begin
            return 8'd0;
        end else if (roll < 35) begin
            return 8'($urandom_range(129, 255));
        end else if (roll < 55) begin
            return 8'($urandom_range(2, 8));
        end
        return 8'($urandom_range(1, 128));
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return 1;
        end else if (roll < 80) begin
            return $urandom_range(2, 8);
        end else if (roll < 95) begin
            return $urandom_range(9, 20);
        end
        return $urandom_range(21, 40);
    endfunction

    task automatic send_entry(input logic [7:0] v, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{value: v, is_last: last};
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        entries_sent++;
    endtask

    // The block may still be walking the row after an entry with no result,
    // so the write also waits out one full entry and row sum.
    task automatic set_max(input logic [7:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_max = v;
    endtask

    // Entries follow a legal walk so that counts stay nonzero; some are
    // pinned to the walk and a few are random noise.
    task automatic send_array(input int len, input int split_at);
        int         lim;
        int         pos;
        int         fix_pct;
        int         roll;
        logic [7:0] v;
        lim = eff_max(cur_max);
        pos = $urandom_range(1, lim);
        fix_pct = $urandom_range(0, 60);
        for (int i = 0; i < len; i++) begin
            if (i == split_at) begin
                set_max(pick_max());
                lim = eff_max(cur_max);
            end
            if (i > 0) begin
                pos = pos + int'($urandom_range(0, 2)) - 1;
            end
            if (pos < 1) begin
                pos = 1;
            end
            if (pos > lim) begin
                pos = lim;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                v = 8'($urandom_range(0, 128));
            end else if (roll < 8 + fix_pct) begin
                v = 8'(pos);
            end else begin
                v = 8'd0;
            end
            send_entry(v, i == len - 1);
        end
    endtask

    initial begin
        int arrays_left;
        int len;
        int split_at;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        s_valid = 1'b0;
        s_data = '0;
        cur_max = cacd_pkg::MAX_VALUE_RST;
        entries_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_entry(8'd0, 1'b1);
        send_entry(8'd128, 1'b1);
        send_entry(8'd1, 1'b0);
        send_entry(8'd0, 1'b0);
        send_entry(8'd0, 1'b1);
        set_max(8'd3);
        send_entry(8'd0, 1'b0);
        send_entry(8'd5, 1'b0);
        send_entry(8'd0, 1'b1);
        send_entry(8'd3, 1'b0);
        send_entry(8'd2, 1'b0);
        send_entry(8'd1, 1'b1);
        set_max(8'd0);
        send_entry(8'd0, 1'b0);
        send_entry(8'd1, 1'b1);
        send_entry(8'd2, 1'b1);
        set_max(8'd255);
        send_entry(8'd0, 1'b0);
        send_entry(8'd127, 1'b0);
        send_entry(8'd0, 1'b1);
        set_max(8'd2);
        send_entry(8'd0, 1'b0);
        send_entry(8'd0, 1'b0);
        set_max(8'd128);
        send_entry(8'd0, 1'b0);
        send_entry(8'd3, 1'b1);

        entries_sent = 0;
        arrays_left = 0;
        while (entries_sent < RANDOM_ENTRIES) begin
            if (arrays_left == 0) begin
                set_max(pick_max());
                arrays_left = $urandom_range(3, 15);
            end
            arrays_left--;
            quiet_mode <= ($urandom_range(0, 99) < 20);
            len = pick_length();
            split_at = -1;
            if (len > 1 && $urandom_range(0, 29) == 0) begin
                split_at = $urandom_range(1, len - 1);
            end
            send_array(len, split_at);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_constrained_array_count_dp_top passed");
        end else begin
            $display("tb_constrained_array_count_dp_top failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_constrained_array_count_dp_top failed");
        $finish;
    end

endmodule
